>>> design/grrs_pkg.sv
// Package for the grouped round-robin task scheduler.
// Holds sizes, opcodes, status codes, controller states and command structs.
// No dependencies.
package grrs_pkg;
  localparam int MAX_GROUPS   = 16;
  localparam int MAX_TASKS    = 64;
  localparam int TASK_ID_BITS = 22;
  localparam int GW = $clog2(MAX_GROUPS);
  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = $clog2(MAX_GROUPS + 1);

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SWITCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;   // capture inputs
    logic find;   // run group search
    logic rd;     // read slot memories for head
    logic exec;   // commit and emit result
  } cmd_t;
endpackage

>>> design/grouped_round_robin_task_scheduler.sv
// Top level of the grouped round-robin task scheduler.
// Depends on grrs_pkg, grrs_ctrl, grrs_dp.
//
// Usage:
//   Raise start with in_op, in_task_id and in_group_id; the command transfers
//   at a rising edge with start high and busy low. busy then stays high through
//   the find, read and exec steps, and the result shows on the out_ ports for
//   exactly one cycle with out_valid high, in the cycle after exec. A new
//   command may transfer in that same result cycle. The group search and the
//   slot-pool read through the registered link RAM are why a command passes
//   through these steps.
//   The receiver cannot stall: take each result in its strobe cycle.
//   Reset (rst_n low, synchronous) clears all groups, ring counts and frees
//   every task slot; no clearing pass is needed.
module grouped_round_robin_task_scheduler import grrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [21:0] in_task_id,
  input  logic [63:0] in_group_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_wake_valid,
  output logic [21:0] out_wake_task_id,
  output logic        out_caller_sleeps,
  output logic        out_group_removed
);
  cmd_t cmd;

  // Sequence each command through its steps.
  grrs_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .cmd);

  // Hold the tables and produce the result.
  grrs_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_op, .in_task_id(in_task_id[TASK_ID_BITS-1:0]), .in_group_id,
    .out_valid, .out_status, .out_wake_valid, .out_wake_task_id,
    .out_caller_sleeps, .out_group_removed);
endmodule

>>> design/grrs_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No package dependencies.
module grrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/grrs_ctrl.sv
// Controller state machine of the scheduler: sequences load, find, read, exec.
// Depends on grrs_pkg.
module grrs_ctrl import grrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_FIND;
      S_FIND: state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: cmd.load = start;
      S_FIND: cmd.find = 1'b1;
      S_READ: cmd.rd   = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      default: ;
    endcase
  end

  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> cmd.exec) else $error("exec must follow read");
  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load) else $error("load while busy");
  a_onehot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("overlapping commands");
endmodule

>>> design/grrs_dp.sv
// Datapath of the scheduler: group table, ring pointers, slot pool memories.
// Depends on grrs_pkg and grrs_ram.
module grrs_dp import grrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic [1:0]              in_op,
  input  logic [TASK_ID_BITS-1:0] in_task_id,
  input  logic [63:0]             in_group_id,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic                    out_wake_valid,
  output logic [21:0]             out_wake_task_id,
  output logic                    out_caller_sleeps,
  output logic                    out_group_removed
);
  // Group table in flops (small, searched in parallel).
  logic [MAX_GROUPS-1:0] gvalid_r;
  logic [63:0]           gkey_r   [MAX_GROUPS];
  logic [GW-1:0]         grank_r  [MAX_GROUPS];
  logic [SW-1:0]         ghead_r  [MAX_GROUPS];
  logic [SW-1:0]         gtail_r  [MAX_GROUPS];
  logic [CW-1:0]         gcount_r [MAX_GROUPS];
  logic [TASK_ID_BITS-1:0] headtask_r [MAX_GROUPS]; // shadow of slot_task[head]
  logic [TW-1:0]         total_r;
  logic [MAX_TASKS-1:0]  sfree_r;

  // Captured command.
  logic [1:0]              op_r;
  logic [TASK_ID_BITS-1:0] id_r;
  logic [63:0]             key_r;

  // Search results.
  logic          hit_r, gfound_r;
  logic [GW-1:0] g_r, fg_r;
  logic          fs_ok_r;
  logic [SW-1:0] fs_r;

  // Slot memories.
  logic          task_we, link_we;
  logic [SW-1:0] task_wa, link_wa, link_ra;
  logic [TASK_ID_BITS-1:0] task_wd, nxtask;
  logic [SW-1:0] link_wd, nx;
  logic [SW-1:0] task_ra;

  // Head link for create-existing and tail link for delete land in the cycle
  // after exec, through the same link RAM port.
  logic          post_we_r;
  logic [SW-1:0] post_wa_r, post_wd_r;
  logic          link_we_m;
  logic [SW-1:0] link_wa_m, link_wd_m;

  grrs_ram #(.WIDTH(TASK_ID_BITS), .DEPTH(MAX_TASKS)) u_task (
    .clk, .we(task_we), .waddr(task_wa), .wdata(task_wd),
    .raddr(task_ra), .rdata(nxtask));
  grrs_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_link (
    .clk, .we(link_we_m), .waddr(link_wa_m), .wdata(link_wd_m),
    .raddr(link_ra), .rdata(nx));

  // Exec writes and post writes fall in different cycles: the controller
  // idles after exec.
  assign link_we_m = link_we | post_we_r;
  assign link_wa_m = post_we_r ? post_wa_r : link_wa;
  assign link_wd_m = post_we_r ? post_wd_r : link_wd;

  // Find step: combinational search over flop table.
  logic          f_hit, f_gfound, f_fsok;
  logic [GW-1:0] f_g, f_fg;
  logic [SW-1:0] f_fs;
  logic [MAX_GROUPS-1:0] f_run;
  logic          f_older;
  always_comb begin
    f_hit = 1'b0; f_g = '0; f_gfound = 1'b0; f_fg = '0;
    f_fsok = 1'b0; f_fs = '0; f_run = '0; f_older = 1'b0;
    for (int g = MAX_GROUPS-1; g >= 0; g--) begin
      if (!gvalid_r[g]) begin f_gfound = 1'b1; f_fg = GW'(g); end
    end
    for (int s = MAX_TASKS-1; s >= 0; s--) begin
      if (sfree_r[s]) begin f_fsok = 1'b1; f_fs = SW'(s); end
    end
    if (op_r == OP_CREATE) begin
      for (int g = MAX_GROUPS-1; g >= 0; g--)
        if (gvalid_r[g] && gkey_r[g] == key_r) begin f_hit = 1'b1; f_g = GW'(g); end
    end else begin
      for (int g = 0; g < MAX_GROUPS; g++)
        f_run[g] = gvalid_r[g] && gcount_r[g] != '0 && headtask_r[g] == id_r;
      // Ranks are unique, so the oldest match has no older match beside it.
      for (int g = 0; g < MAX_GROUPS; g++) begin
        f_older = 1'b0;
        for (int k = 0; k < MAX_GROUPS; k++)
          if (f_run[k] && grank_r[k] < grank_r[g]) f_older = 1'b1;
        if (f_run[g] && !f_older) begin
          f_hit = 1'b1; f_g = GW'(g);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; id_r <= in_task_id; key_r <= in_group_id;
    end
    if (cmd.find) begin
      hit_r <= f_hit; g_r <= f_g; gfound_r <= f_gfound; fg_r <= f_fg;
      fs_ok_r <= f_fsok; fs_r <= f_fs;
    end
  end

  // Read step: link of head in the read cycle, task of that successor in exec.
  logic [SW-1:0] h;
  assign h       = ghead_r[g_r];
  assign link_ra = h;
  assign task_ra = nx;

  // Exec computes pointers; the post cycle resolves the wake id.
  logic          post_r;
  logic          pend_wake_r;
  logic [1:0]    res_status_r;
  logic          res_sleeps_r, res_removed_r;
  logic [GW-1:0] pg_r;
  logic          pupd_r;

  always_comb begin
    task_we = 1'b0; task_wa = fs_r; task_wd = id_r;
    link_we = 1'b0; link_wa = fs_r; link_wd = fs_r;
    if (cmd.exec && op_r == OP_CREATE && fs_ok_r && (hit_r || gfound_r)) begin
      task_we = 1'b1;
      link_we = 1'b1;
      link_wd = hit_r ? nx : fs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvalid_r <= '0; total_r <= '0; sfree_r <= '1; post_r <= 1'b0;
      post_we_r <= 1'b0;
      for (int g = 0; g < MAX_GROUPS; g++) gcount_r[g] <= '0;
    end else begin
      post_r <= cmd.exec;
      post_we_r <= 1'b0;
      if (cmd.exec) begin
        res_status_r <= ST_OK; res_sleeps_r <= 1'b0; res_removed_r <= 1'b0;
        pend_wake_r <= 1'b0; pg_r <= g_r; pupd_r <= 1'b0;
        case (op_r)
          OP_CREATE: begin
            if (!fs_ok_r || !(hit_r || gfound_r)) res_status_r <= ST_FULL;
            else begin
              sfree_r[fs_r] <= 1'b0;
              if (!hit_r) begin
                gvalid_r[fg_r] <= 1'b1; gkey_r[fg_r] <= key_r;
                grank_r[fg_r] <= GW'(total_r); total_r <= total_r + TW'(1);
                ghead_r[fg_r] <= fs_r; gtail_r[fg_r] <= fs_r;
                gcount_r[fg_r] <= CW'(1); headtask_r[fg_r] <= id_r;
              end else begin
                post_we_r <= 1'b1; post_wa_r <= h; post_wd_r <= fs_r;
                if (gtail_r[g_r] == h) gtail_r[g_r] <= fs_r;
                gcount_r[g_r] <= gcount_r[g_r] + CW'(1);
                res_sleeps_r <= 1'b1;
              end
            end
          end
          OP_SWITCH, OP_DELETE: begin
            if (!hit_r) res_status_r <= ST_UNKNOWN;
            else if (op_r == OP_SWITCH) begin
              if (gcount_r[g_r] > CW'(1)) begin
                gtail_r[g_r] <= h; ghead_r[g_r] <= nx; pend_wake_r <= 1'b1;
                pupd_r <= 1'b1;
              end
            end else begin
              sfree_r[h] <= 1'b1;
              gcount_r[g_r] <= gcount_r[g_r] - CW'(1);
              if (gcount_r[g_r] > CW'(1)) begin
                post_we_r <= 1'b1; post_wa_r <= gtail_r[g_r]; post_wd_r <= nx;
                ghead_r[g_r] <= nx; pend_wake_r <= 1'b1; pupd_r <= 1'b1;
              end else begin
                for (int k = 0; k < MAX_GROUPS; k++)
                  if (gvalid_r[k] && grank_r[k] > grank_r[g_r])
                    grank_r[k] <= grank_r[k] - GW'(1);
                gvalid_r[g_r] <= 1'b0;
                if (total_r != '0) total_r <= total_r - TW'(1);
                res_removed_r <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      if (post_r && pupd_r) headtask_r[pg_r] <= nxtask;
    end
  end

  // Outputs in post cycle.
  logic wake;
  assign wake = pend_wake_r && (nxtask != id_r);
  assign out_valid         = post_r;
  assign out_status        = res_status_r;
  assign out_wake_valid    = post_r & wake;
  assign out_wake_task_id  = wake ? 22'(nxtask) : '0;
  assign out_caller_sleeps = res_sleeps_r | (wake && op_r == OP_SWITCH);
  assign out_group_removed = res_removed_r;
endmodule
